/* hdl/indexed_list_move_to_front_macros.svh */
// Assertion macros shared by the list block.
`ifndef INDEXED_LIST_MOVE_TO_FRONT_MACROS_SVH
`define INDEXED_LIST_MOVE_TO_FRONT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ILMTF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ILMTF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list check failed");

`endif

/* hdl/ilmtf_pkg.sv */
`default_nettype none

package ilmtf_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int FUNC_W = 3;
  localparam int POS_W  = 6;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;
  localparam int FILL_W = 7;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD_TAIL = 3'd0,
    FN_ADD_HEAD = 3'd1,
    FN_REMOVE   = 3'd2,
    FN_READ     = 3'd3,
    FN_MOVE     = 3'd4,
    FN_CLEAR    = 3'd5
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // What every cell of the row does on the coming clock edge.
  typedef enum logic [2:0] {
    CO_HOLD,
    CO_PUSH_HEAD,
    CO_PUT_TAIL,
    CO_REMOVE,
    CO_MOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [IDX_W-1:0]  pos;
    logic [IDX_W-1:0]  tail;
    logic [WORD_W-1:0] new_word;
    logic [WORD_W-1:0] head_word;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* hdl/ilmtf_cell.sv */
`default_nettype none

module ilmtf_cell (
  input  wire logic                         clk,
  input  wire logic [ilmtf_pkg::IDX_W-1:0]  cell_idx,
  input  wire ilmtf_pkg::cell_ctrl_t        ctrl,
  input  wire logic [ilmtf_pkg::IDX_W-1:0]  pick_pos,
  input  wire logic [ilmtf_pkg::WORD_W-1:0] left_word,
  input  wire logic [ilmtf_pkg::WORD_W-1:0] right_word,
  output logic      [ilmtf_pkg::WORD_W-1:0] word,
  output logic      [ilmtf_pkg::WORD_W-1:0] pick_word
);
  import ilmtf_pkg::*;

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;
  logic              at_head;

  assign at_head = (cell_idx == '0);

  always_comb begin
    unique case (ctrl.op)
      CO_PUSH_HEAD: word_nxt = at_head ? ctrl.new_word : left_word;
      CO_PUT_TAIL:  word_nxt = (cell_idx == ctrl.tail) ? ctrl.new_word : word_r;
      CO_REMOVE:    word_nxt = (cell_idx >= ctrl.pos) ? right_word : word_r;
      CO_MOVE: begin
        if (at_head) begin
          word_nxt = ctrl.head_word;
        end else if (cell_idx <= ctrl.pos) begin
          word_nxt = left_word;
        end else begin
          word_nxt = word_r;
        end
      end
      default:      word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word      = word_r;
  // Only the cell at the addressed position puts its word on the read bus.
  assign pick_word = (cell_idx == pick_pos) ? word_r : '0;

endmodule

`default_nettype wire

/* hdl/indexed_list_move_to_front.sv */
`default_nettype none

// An ordered list of up to CAPACITY (64) data words held in a row of cells,
// one word per cell, with position 0 at the head. An item is taken on any
// rising edge where start is high and busy is low; busy never rises, so a
// new item may be offered on every cycle. Every operation (add at tail, add
// at head, remove, read, move to head, clear) is done in the edge that takes
// it, because all cells shift together in that edge: the result for an
// item appears on the out_ ports, flagged by out_strobe, in the cycle
// straight after the accepting edge, and lasts exactly one cycle. The
// receiver cannot hold results off, so it must take every strobe. The rate
// is therefore one item per cycle, as the whole row shifts in the accepting
// edge. Words are not cleared by reset; only the fill count and the strobe
// are, and no unwritten entry is ever returned.

module indexed_list_move_to_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [ilmtf_pkg::FUNC_W-1:0] in_func,
  input  wire logic [ilmtf_pkg::POS_W-1:0]  in_position,
  input  wire logic [ilmtf_pkg::WORD_W-1:0] in_payload,
  output logic                              out_strobe,
  output logic      [ilmtf_pkg::STAT_W-1:0] out_status,
  output logic      [ilmtf_pkg::WORD_W-1:0] out_word_out,
  output logic      [ilmtf_pkg::FILL_W-1:0] out_fill
);
  import ilmtf_pkg::*;

  // Cell row and its read bus.
  cell_ctrl_t        ctrl;
  logic [WORD_W-1:0] cell_word [CAPACITY];
  logic [WORD_W-1:0] cell_pick [CAPACITY];
  logic [WORD_W-1:0] picked;

  // List bookkeeping.
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              accept;
  logic              is_full;
  logic              is_empty;
  logic              in_range;

  // Result register.
  logic              strobe_r;
  status_t           status_r;
  status_t           status_nxt;
  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;
  logic [FILL_W-1:0] fill_r;

  // Every operation completes in the edge that takes it.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);
  assign in_range = (32'(in_position) < 32'(count_r));

  // The addressed cell alone drives a non-zero word, so an OR gathers it.
  always_comb begin
    picked = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      picked = picked | cell_pick[i];
    end
  end

  // Decode the item into a command for the row, a status and the new count.
  always_comb begin
    ctrl.op        = CO_HOLD;
    ctrl.pos       = IDX_W'(in_position);
    ctrl.tail      = IDX_W'(count_r);
    ctrl.new_word  = in_payload;
    ctrl.head_word = picked;
    count_nxt      = count_r;
    status_nxt     = ST_OK;
    word_nxt       = '0;
    if (accept) begin
      unique case (in_func)
        FN_ADD_TAIL, FN_ADD_HEAD: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            ctrl.op   = (in_func == FN_ADD_TAIL) ? CO_PUT_TAIL : CO_PUSH_HEAD;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        FN_REMOVE: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else if (!in_range) begin
            status_nxt = ST_RANGE;
          end else begin
            ctrl.op   = CO_REMOVE;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        FN_READ: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else if (!in_range) begin
            status_nxt = ST_RANGE;
          end else begin
            word_nxt = picked;
          end
        end
        FN_MOVE: begin
          // A position past the end leaves the list alone but still reports
          // the word at the head.
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else if (!in_range) begin
            status_nxt = ST_RANGE;
            word_nxt   = cell_word[0];
          end else begin
            ctrl.op  = CO_MOVE;
            word_nxt = picked;
          end
        end
        FN_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          // Unused function codes are answered with an ok and no change.
        end
      endcase
    end
  end

  // The row of cells; the end cells see their own word past the edge. The
  // read bus is addressed straight from the input position, so that the
  // word it gathers does not pass back through the row command.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ilmtf_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(g)),
      .ctrl       (ctrl),
      .pick_pos   (IDX_W'(in_position)),
      .left_word  (cell_word[(g == 0) ? 0 : g - 1]),
      .right_word (cell_word[(g == CAPACITY - 1) ? g : g + 1]),
      .word       (cell_word[g]),
      .pick_word  (cell_pick[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    word_r   <= word_nxt;
    fill_r   <= FILL_W'(count_nxt);
  end

  assign out_strobe   = strobe_r;
  assign out_status   = status_r;
  assign out_word_out = word_r;
  assign out_fill     = fill_r;

`include "indexed_list_move_to_front_macros.svh"

  // Each taken item yields its result in the very next cycle, and only then.
  `ILMTF_ASSERT_NXT(a_strobe_follows, accept, out_strobe)
  `ILMTF_ASSERT_NXT(a_no_spurious, !accept, !out_strobe)
  // The count never passes the capacity.
  `ILMTF_ASSERT_IMP(a_count_bound, 1'b1, 32'(count_r) <= 32'(CAPACITY))
  // A refused add is only ever reported against a full list.
  `ILMTF_ASSERT_IMP(a_full_means_full, out_strobe && (out_status == ST_FULL), out_fill == FILL_W'(CAPACITY))
  // The count moves by at most one, or drops to zero on a clear.
  `ILMTF_ASSERT_NXT(a_count_step, 1'b1, (count_r == $past(count_r)) || (count_r == $past(count_r) + CNT_W'(1)) || (count_r == $past(count_r) - CNT_W'(1)) || (count_r == '0))

endmodule

`default_nettype wire

/* sim/tb_indexed_list_move_to_front.sv */
`timescale 1ns / 1ps

module tb_indexed_list_move_to_front;
  import ilmtf_pkg::*;

  // Function codes that the block must treat as no-ops.
  localparam logic [FUNC_W-1:0] FN_UNUSED_A = 3'd6;
  localparam logic [FUNC_W-1:0] FN_UNUSED_B = 3'd7;

  localparam int TOTAL_REQUESTS = 1450;
  localparam int NUM_PHASES     = 4;
  localparam int STALL_LIMIT    = 1000;
  localparam int DRAIN_LIMIT    = 100;
  localparam int REPORT_LIMIT   = 10;

  // One reply as the list should give it.
  typedef struct {
    status_t           status;
    logic [WORD_W-1:0] word;
    logic [FILL_W-1:0] fill;
  } list_reply_t;

  // The scoreboard keeps its own copy of the list. Each accepted item is
  // applied to that copy at once, and the reply it must cause is queued.
  class list_scoreboard;
    logic [WORD_W-1:0] shadow_words [CAPACITY];
    int                depth;
    list_reply_t       expected_replies [$];
    int                mismatches;

    function void note_request(logic [FUNC_W-1:0] func, logic [POS_W-1:0] pos,
                               logic [WORD_W-1:0] payload);
      list_reply_t reply;
      logic [WORD_W-1:0] moved;
      int i;
      reply.status = ST_OK;
      reply.word   = '0;
      case (func)
        FN_ADD_TAIL: begin
          if (depth >= CAPACITY) begin
            reply.status = ST_FULL;
          end else begin
            shadow_words[depth] = payload;
            depth++;
          end
        end
        FN_ADD_HEAD: begin
          if (depth >= CAPACITY) begin
            reply.status = ST_FULL;
          end else begin
            for (i = depth; i > 0; i--) shadow_words[i] = shadow_words[i-1];
            shadow_words[0] = payload;
            depth++;
          end
        end
        FN_REMOVE: begin
          if (depth == 0) begin
            reply.status = ST_EMPTY;
          end else if (int'(pos) >= depth) begin
            reply.status = ST_RANGE;
          end else begin
            for (i = pos; i + 1 < depth; i++) shadow_words[i] = shadow_words[i+1];
            depth--;
          end
        end
        FN_READ: begin
          if (depth == 0) begin
            reply.status = ST_EMPTY;
          end else if (int'(pos) >= depth) begin
            reply.status = ST_RANGE;
          end else begin
            reply.word = shadow_words[pos];
          end
        end
        FN_MOVE: begin
          if (depth == 0) begin
            reply.status = ST_EMPTY;
          end else if (int'(pos) >= depth) begin
            reply.status = ST_RANGE;
            reply.word   = shadow_words[0];
          end else begin
            moved = shadow_words[pos];
            for (i = pos; i > 0; i--) shadow_words[i] = shadow_words[i-1];
            shadow_words[0] = moved;
            reply.word      = moved;
          end
        end
        FN_CLEAR: begin
          depth = 0;
        end
        default: begin
        end
      endcase
      reply.fill = FILL_W'(depth);
      expected_replies.push_back(reply);
    endfunction

    function void check_reply(logic [STAT_W-1:0] status, logic [WORD_W-1:0] word,
                              logic [FILL_W-1:0] fill);
      list_reply_t want;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected reply: status %0d word %h fill %0d", status, word, fill);
        return;
      end
      want = expected_replies.pop_front();
      if (status !== want.status || word !== want.word || fill !== want.fill) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display({"reply mismatch: status exp %0d got %0d, word exp %h got %h, ",
                    "fill exp %0d got %0d"},
                   want.status, status, want.word, word, want.fill, fill);
      end
    endfunction

    function void close_out();
      if (expected_replies.size() != 0) begin
        mismatches += expected_replies.size();
        $display("%0d replies never arrived", expected_replies.size());
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [FUNC_W-1:0]   in_func;
  logic [POS_W-1:0]    in_position;
  logic [WORD_W-1:0]   in_payload;
  logic                out_strobe;
  logic [STAT_W-1:0]   out_status;
  logic [WORD_W-1:0]   out_word_out;
  logic [FILL_W-1:0]   out_fill;

  list_scoreboard sb;
  int             requests_sent;
  int             idle_pct;
  int             quiet_cycles;

  indexed_list_move_to_front u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_position  (in_position),
    .in_payload   (in_payload),
    .out_strobe   (out_strobe),
    .out_status   (out_status),
    .out_word_out (out_word_out),
    .out_fill     (out_fill)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Replies are sampled on the rising edge that ends their strobe cycle. The
  // block cannot be held off, so every strobe is taken and checked here.
  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_reply(out_status, out_word_out, out_fill);
  end

  // The watchdog counts cycles in which neither an item nor a reply moves.
  // A correct run never goes quiet for long, as sender gaps are short.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item and holds it until the block takes it. Before the offer
  // the sender stays idle on each cycle with the phase's idle chance. The
  // item is noted in the scoreboard by this task, so that the shadow fill
  // count is already up to date when the next item is chosen. Inputs change
  // only through nonblocking assignments at the rising edge, and busy is
  // read straight after the edge, so it holds the value that the edge saw.
  task automatic offer_request(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos,
                               input logic [WORD_W-1:0] payload);
    while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_func     <= func;
    in_position <= pos;
    in_payload  <= payload;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(func, pos, payload);
    requests_sent++;
  endtask

  // Picks a position that is usually inside the list, so that most removes,
  // reads and moves do real work, with the rest spread over the whole field.
  function automatic logic [POS_W-1:0] pick_position();
    if (sb.depth > 0 && $urandom_range(99, 0) < 85)
      return POS_W'($urandom_range(sb.depth - 1, 0));
    return POS_W'($urandom_range(63, 0));
  endfunction

  // One random item. Adds are favoured while the list is short so that the
  // fill level wanders over its whole range, full list included.
  task automatic random_request();
    int                roll;
    int                add_weight;
    logic [FUNC_W-1:0] func;
    roll       = $urandom_range(99, 0);
    add_weight = (sb.depth < 32) ? 42 : 22;
    if (roll < 2) begin
      func = roll[0] ? FN_UNUSED_A : FN_UNUSED_B;
    end else if (roll < 3) begin
      func = FN_CLEAR;
    end else if (roll < 3 + add_weight) begin
      func = roll[0] ? FN_ADD_HEAD : FN_ADD_TAIL;
    end else begin
      case (roll % 3)
        0:       func = FN_REMOVE;
        1:       func = FN_READ;
        default: func = FN_MOVE;
      endcase
    end
    offer_request(func, pick_position(), $urandom);
  endtask

  // Fills the list to capacity, knocks on it twice while full, and then
  // works at the far end, where the deepest shifts happen.
  task automatic fill_to_capacity();
    while (sb.depth < CAPACITY)
      offer_request($urandom_range(1, 0) ? FN_ADD_HEAD : FN_ADD_TAIL,
                    POS_W'($urandom_range(63, 0)), $urandom);
    offer_request(FN_ADD_TAIL, POS_W'($urandom_range(63, 0)), $urandom);
    offer_request(FN_ADD_HEAD, POS_W'($urandom_range(63, 0)), $urandom);
    offer_request(FN_READ, 6'd63, $urandom);
    offer_request(FN_MOVE, 6'd63, $urandom);
    offer_request(FN_READ, 6'd0, $urandom);
    offer_request(FN_REMOVE, 6'd63, $urandom);
    offer_request(FN_MOVE, 6'd62, $urandom);
  endtask

  initial begin
    int phase;
    int waited;
    int phase_idle [NUM_PHASES];

    sb            = new();
    requests_sent = 0;
    idle_pct      = 0;
    quiet_cycles  = 0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_func       = '0;
    in_position   = '0;
    in_payload    = '0;

    // Sender idling per phase: none, heavy, none again, light. The receiver
    // cannot stall, so the phases differ only on the sending side.
    phase_idle[0] = 0;
    phase_idle[1] = 73;
    phase_idle[2] = 0;
    phase_idle[3] = 17;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The empty list comes first: remove, read and move all
    // report empty, and the unused function codes do nothing.
    offer_request(FN_REMOVE, 6'd0, $urandom);
    offer_request(FN_READ, 6'd0, $urandom);
    offer_request(FN_MOVE, 6'd5, $urandom);
    offer_request(FN_UNUSED_A, 6'd63, 32'hFFFF_FFFF);
    offer_request(FN_UNUSED_B, 6'd0, 32'h0000_0000);
    // A short list built from the extreme data words.
    offer_request(FN_ADD_TAIL, 6'd0, 32'h0000_0000);
    offer_request(FN_ADD_HEAD, 6'd63, 32'hFFFF_FFFF);
    offer_request(FN_ADD_TAIL, 6'd0, 32'hA5A5_A5A5);
    offer_request(FN_READ, 6'd0, $urandom);
    offer_request(FN_READ, 6'd2, $urandom);
    // Positions past the fill count: remove and read are refused with no
    // data, whereas a move that is refused still gives the head word.
    offer_request(FN_READ, 6'd63, $urandom);
    offer_request(FN_REMOVE, 6'd3, $urandom);
    offer_request(FN_MOVE, 6'd63, $urandom);
    // Moving the head leaves the list as it was; moving the tail rotates it.
    offer_request(FN_MOVE, 6'd0, $urandom);
    offer_request(FN_MOVE, 6'd2, $urandom);
    offer_request(FN_READ, 6'd0, $urandom);
    offer_request(FN_REMOVE, 6'd0, $urandom);
    offer_request(FN_REMOVE, 6'd1, $urandom);
    offer_request(FN_READ, 6'd0, $urandom);
    // Clear always succeeds, and the list reads as empty afterwards.
    offer_request(FN_CLEAR, 6'd0, $urandom);
    offer_request(FN_READ, 6'd0, $urandom);
    offer_request(FN_ADD_HEAD, 6'd0, 32'h5A5A_5A5A);
    offer_request(FN_CLEAR, 6'd63, $urandom);

    // Random part, in phases of different sender idling. Each phase opens
    // with a run up to a full list and then goes on at random.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      idle_pct = phase_idle[phase];
      fill_to_capacity();
      while (requests_sent < (phase + 1) * TOTAL_REQUESTS / NUM_PHASES)
        random_request();
    end

    start    <= 1'b0;
    idle_pct = 0;

    // Let the last replies come in, then wait on in case a stray strobe
    // follows.
    waited = 0;
    while (sb.expected_replies.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);

    sb.close_out();
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
